>>> design/cls_pkg.sv
// Shared types, constants and helpers for the consensus log store.
package cls_pkg;

   localparam int LOG_DEPTH    = 1024;
   localparam int PAYLOAD_BITS = 64;
   localparam int SLOT_W       = $clog2(LOG_DEPTH);
   localparam int CNT_W        = $clog2(LOG_DEPTH + 1);
   localparam int SUM_W        = CNT_W + 1;
   localparam int REQ_W        = 136;
   localparam int RSP_W        = 232;

   localparam logic [2:0] CMD_APPEND  = 3'd0;
   localparam logic [2:0] CMD_DROP    = 3'd1;
   localparam logic [2:0] CMD_COMPACT = 3'd2;
   localparam logic [2:0] CMD_TERM    = 3'd3;
   localparam logic [2:0] CMD_MATCH   = 3'd4;
   localparam logic [2:0] CMD_READ    = 3'd5;
   localparam logic [2:0] CMD_INSTALL = 3'd6;

   localparam logic [1:0] ST_DONE      = 2'd0;
   localparam logic [1:0] ST_FULL      = 2'd1;
   localparam logic [1:0] ST_TRUNC_OOR = 2'd2;
   localparam logic [1:0] ST_READ_OOR  = 2'd3;

   typedef struct packed {
      logic load;
      logic exec;
      logic finish;
   } ctrl_type;

   // ring slot of entry k; head < depth and k <= depth keep one correction enough
   function automatic logic [SLOT_W-1:0] slot_of(input logic [SLOT_W-1:0] head,
                                                 input logic [CNT_W-1:0]  k);
      logic [SUM_W-1:0] sum;
      sum = SUM_W'(head) + SUM_W'(k);
      if (sum >= SUM_W'(LOG_DEPTH)) begin
         sum = sum - SUM_W'(LOG_DEPTH);
      end
      return sum[SLOT_W-1:0];
   endfunction

endpackage

>>> design/consensus_log_store.sv
// Consensus log store top level: ring-buffer log of (term, payload) entries.
// Usage:
//   req_* channel carries one command per transfer (append, drop from index,
//   compact before index, get term, match, read entry, install snapshot).
//   rsp_* channel returns exactly one result per command, in order, with the
//   log bounds (first, last, snapshot index, last term) after that command.
// Flow: a command first accesses the entry memory, then updates the pointers
//   and writes the output register; the update waits while that register
//   holds a result that rsp_tready does not take. A new command is accepted
//   at the earliest as the previous one finishes its pointer update.
// A result waiting in the output register does not block the next command;
//   while rsp_tready stays low the second result is held back and req_tready
//   drops until the output register drains.
// Reset: empty log, first index 1, snapshot index 1, snapshot term 0. Entry
//   memory contents are not cleared; only data read from slots holding entries is used.
module consensus_log_store
   import cls_pkg::*;
(
   input  logic             clock,
   input  logic             reset,
   input  logic             req_tvalid,
   output logic             req_tready,
   // cmd[2:0], index[34:3], term[66:35], payload[130:67], zero[135:131]
   input  logic [REQ_W-1:0] req_tdata,
   output logic             rsp_tvalid,
   input  logic             rsp_tready,
   // status[1:0], result_term[33:2], result_payload[97:34], matched[98],
   // last_index[130:99], last_term[162:131], first_index[194:163],
   // snap_index[226:195], zero[231:227]
   output logic [RSP_W-1:0] rsp_tdata
);

   ctrl_type ctrl;

   cls_ctrl u_ctrl (
      .clock      (clock),
      .reset      (reset),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .ctrl       (ctrl)
   );

   cls_datapath u_datapath (
      .clock     (clock),
      .reset     (reset),
      .ctrl      (ctrl),
      .req_tdata (req_tdata),
      .rsp_tdata (rsp_tdata)
   );

`ifndef SYNTHESIS
   a_finish_shows: assert property (@(posedge clock) disable iff (reset)
      ctrl.finish |=> rsp_tvalid)
      else $error("completed command did not raise rsp_tvalid");

   a_one_in_flight: assert property (@(posedge clock) disable iff (reset)
      (req_tvalid && req_tready) |=> !req_tready)
      else $error("second command accepted while one is executing");

   a_finish_needs_room: assert property (@(posedge clock) disable iff (reset)
      ctrl.finish |-> (!rsp_tvalid || rsp_tready))
      else $error("result overwritten before transfer");
`endif

endmodule

>>> design/cls_ctrl.sv
// Command sequencer and result valid tracking for the consensus log store.
module cls_ctrl
   import cls_pkg::*;
(
   input  logic     clock,
   input  logic     reset,
   input  logic     req_tvalid,
   output logic     req_tready,
   output logic     rsp_tvalid,
   input  logic     rsp_tready,
   output ctrl_type ctrl
);

   typedef enum logic [2:0] {
      S_IDLE = 3'b001,
      S_EXEC = 3'b010,
      S_RESP = 3'b100
   } state_type;

   state_type state_ff, state_in;
   logic      rsp_valid_ff, rsp_valid_in;
   logic      out_free;

   always_comb begin
      out_free    = !rsp_valid_ff || rsp_tready;
      ctrl.finish = (state_ff == S_RESP) && out_free;
      req_tready  = (state_ff == S_IDLE) || ctrl.finish;
      ctrl.load   = req_tvalid && req_tready;
      ctrl.exec   = (state_ff == S_EXEC);

      state_in = state_ff;
      case (state_ff)
         S_IDLE: begin
            if (ctrl.load) state_in = S_EXEC;
         end
         S_EXEC: begin
            state_in = S_RESP;
         end
         S_RESP: begin
            if (ctrl.finish) state_in = ctrl.load ? S_EXEC : S_IDLE;
         end
         default: begin
            state_in = S_IDLE;
         end
      endcase

      if (ctrl.finish) begin
         rsp_valid_in = 1'b1;
      end else if (rsp_tready) begin
         rsp_valid_in = 1'b0;
      end else begin
         rsp_valid_in = rsp_valid_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= S_IDLE;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   assign rsp_tvalid = rsp_valid_ff;

endmodule

>>> design/cls_datapath.sv
// Log storage, pointer registers and result register of the consensus log store.
module cls_datapath
   import cls_pkg::*;
(
   input  logic             clock,
   input  logic             reset,
   input  ctrl_type         ctrl,
   input  logic [REQ_W-1:0] req_tdata,
   output logic [RSP_W-1:0] rsp_tdata
);

   logic [2:0]              cmd_ff;
   logic [31:0]             idx_ff;
   logic [31:0]             trm_ff;
   logic [PAYLOAD_BITS-1:0] pay_ff;

   logic [31:0]             term_mem_ff [LOG_DEPTH];
   logic [PAYLOAD_BITS-1:0] pay_mem_ff  [LOG_DEPTH];
   logic [31:0]             rd_term_ff;
   logic [PAYLOAD_BITS-1:0] rd_pay_ff;

   logic [SLOT_W-1:0] head_ff, head_in;
   logic [CNT_W-1:0]  count_ff, count_in;
   logic [31:0]       base_ff, base_in;
   logic [31:0]       snum_ff, snum_in;
   logic [31:0]       sterm_ff, sterm_in;
   logic [31:0]       lterm_ff, lterm_in;

   logic              hit_ff, offz_ff, cvalid_ff, full_ff;
   logic [CNT_W-1:0]  off_ff;
   logic [SLOT_W-1:0] head_new_ff;

   logic [31:0]       off;
   logic [CNT_W-1:0]  off_n;
   logic              hit, full, cvalid;
   logic [CNT_W-1:0]  acc_k;
   logic [SLOT_W-1:0] acc_slot;
   logic              wr_en, rd_en;

   logic [1:0]              status;
   logic [31:0]             res_term;
   logic [PAYLOAD_BITS-1:0] res_pay;
   logic                    matched;
   logic [31:0]             last_index;
   logic [RSP_W-1:0]        rsp_data_ff;

   // command latch
   always_ff @(posedge clock) begin
      if (ctrl.load) begin
         cmd_ff <= req_tdata[2:0];
         idx_ff <= req_tdata[34:3];
         trm_ff <= req_tdata[66:35];
         pay_ff <= req_tdata[67 +: PAYLOAD_BITS];
      end
   end

   // execute step: locate entry, one memory access
   always_comb begin
      off    = idx_ff - base_ff;
      off_n  = off[CNT_W-1:0];
      hit    = off < 32'(count_ff);
      full   = count_ff == CNT_W'(LOG_DEPTH);
      cvalid = (off != 32'd0) && (off <= 32'(count_ff));
      case (cmd_ff)
         CMD_APPEND:           acc_k = count_ff;
         CMD_DROP, CMD_COMPACT: acc_k = off_n - CNT_W'(1);
         default:              acc_k = off_n;
      endcase
      acc_slot = slot_of(head_ff, acc_k);
      wr_en    = ctrl.exec && (cmd_ff == CMD_APPEND) && !full;
      rd_en    = ctrl.exec && (cmd_ff != CMD_APPEND);
   end

   always_ff @(posedge clock) begin
      if (wr_en) begin
         term_mem_ff[acc_slot] <= trm_ff;
         pay_mem_ff[acc_slot]  <= pay_ff;
      end
      if (rd_en) begin
         rd_term_ff <= term_mem_ff[acc_slot];
         rd_pay_ff  <= pay_mem_ff[acc_slot];
      end
      if (ctrl.exec) begin
         hit_ff      <= hit;
         offz_ff     <= (off == 32'd0);
         cvalid_ff   <= cvalid;
         full_ff     <= full;
         off_ff      <= off_n;
         head_new_ff <= slot_of(head_ff, off_n);
      end
   end

   // response step: pointer update and result fields
   always_comb begin
      head_in  = head_ff;
      count_in = count_ff;
      base_in  = base_ff;
      snum_in  = snum_ff;
      sterm_in = sterm_ff;
      lterm_in = lterm_ff;
      status   = ST_DONE;
      res_term = 32'd0;
      res_pay  = '0;
      matched  = 1'b0;
      case (cmd_ff)
         CMD_APPEND: begin
            if (full_ff) begin
               status = ST_FULL;
            end else begin
               count_in = count_ff + CNT_W'(1);
               lterm_in = trm_ff;
            end
         end
         CMD_DROP: begin
            if (hit_ff) begin
               count_in = off_ff;
               lterm_in = offz_ff ? sterm_ff : rd_term_ff;
            end else begin
               status = ST_TRUNC_OOR;
            end
         end
         CMD_COMPACT: begin
            if (cvalid_ff) begin
               snum_in  = idx_ff - 32'd1;
               sterm_in = rd_term_ff;
               head_in  = head_new_ff;
               count_in = count_ff - off_ff;
               base_in  = idx_ff;
            end else begin
               status = ST_TRUNC_OOR;
            end
         end
         CMD_TERM: begin
            if (hit_ff) begin
               res_term = rd_term_ff;
            end else if (idx_ff == snum_ff) begin
               res_term = sterm_ff;
            end
         end
         CMD_MATCH: begin
            if (idx_ff == 32'd0) begin
               matched = 1'b1;
            end else if (idx_ff == snum_ff) begin
               matched = (sterm_ff == trm_ff);
            end else if (hit_ff) begin
               matched = (rd_term_ff == trm_ff);
            end
         end
         CMD_READ: begin
            if (hit_ff) begin
               res_term = rd_term_ff;
               res_pay  = rd_pay_ff;
            end else begin
               status = ST_READ_OOR;
            end
         end
         CMD_INSTALL: begin
            snum_in  = idx_ff;
            sterm_in = trm_ff;
            base_in  = idx_ff;
            count_in = '0;
            head_in  = '0;
            lterm_in = trm_ff;
         end
         default: begin
         end
      endcase
      last_index = base_in + 32'(count_in) - 32'd1;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         head_ff  <= '0;
         count_ff <= '0;
         base_ff  <= 32'd1;
         snum_ff  <= 32'd1;
         sterm_ff <= 32'd0;
         lterm_ff <= 32'd0;
      end else if (ctrl.finish) begin
         head_ff  <= head_in;
         count_ff <= count_in;
         base_ff  <= base_in;
         snum_ff  <= snum_in;
         sterm_ff <= sterm_in;
         lterm_ff <= lterm_in;
      end
   end

   always_ff @(posedge clock) begin
      if (ctrl.finish) begin
         rsp_data_ff <= {5'd0, snum_in, base_in, lterm_in, last_index, matched,
                         64'(res_pay), res_term, status};
      end
   end

   assign rsp_tdata = rsp_data_ff;

endmodule

>>> test/cls_checker.sv
// Checker for the consensus log store: tracks the log, predicts each result and compares.
module cls_checker
   import cls_pkg::*;
(
   input  logic             clock,
   input  logic             reset,
   input  logic             req_tvalid,
   input  logic             req_tready,
   input  logic [REQ_W-1:0] req_tdata,
   input  logic             rsp_tvalid,
   input  logic             rsp_tready,
   input  logic [RSP_W-1:0] rsp_tdata,
   output int               fails,
   output int               pending,
   output logic [31:0]      hint_first,
   output logic [CNT_W-1:0] hint_count,
   output logic [31:0]      hint_snap
);

   typedef struct packed {
      logic [1:0]  status;
      logic [31:0] rterm;
      logic [63:0] rpay;
      logic        matched;
      logic [31:0] last_index;
      logic [31:0] last_term;
      logic [31:0] first_index;
      logic [31:0] snap_index;
   } log_result_type;

   logic [31:0]       term_mem [LOG_DEPTH];
   logic [63:0]       pay_mem  [LOG_DEPTH];
   logic [SLOT_W-1:0] log_head;
   logic [CNT_W-1:0]  log_count;
   logic [31:0]       log_base;
   logic [31:0]       snap_num;
   logic [31:0]       snap_term;

   log_result_type expected_q[$];
   log_result_type want;
   log_result_type seen;
   int             mismatches = 0;

   function automatic logic [SLOT_W-1:0] ring_slot(input logic [31:0] k);
      return SLOT_W'((32'(log_head) + k) % LOG_DEPTH);
   endfunction

   task automatic apply_command(input logic [2:0] c, input logic [31:0] idx,
                                input logic [31:0] trm, input logic [63:0] pay,
                                output log_result_type r);
      logic [31:0]       off;
      logic              hit;
      logic [SLOT_W-1:0] s;
      r   = '0;
      off = idx - log_base;
      hit = off < 32'(log_count);
      case (c)
         CMD_APPEND: begin
            if (32'(log_count) >= LOG_DEPTH) begin
               r.status = ST_FULL;
            end else begin
               s = ring_slot(32'(log_count));
               term_mem[s] = trm;
               pay_mem[s]  = pay;
               log_count   = log_count + 1'b1;
            end
         end
         CMD_DROP: begin
            if (hit) log_count = CNT_W'(off);
            else r.status = ST_TRUNC_OOR;
         end
         CMD_COMPACT: begin
            if (off >= 32'd1 && off <= 32'(log_count)) begin
               snap_num  = idx - 32'd1;
               snap_term = term_mem[ring_slot(off - 32'd1)];
               log_head  = ring_slot(off);
               log_count = log_count - CNT_W'(off);
               log_base  = idx;
            end else begin
               r.status = ST_TRUNC_OOR;
            end
         end
         CMD_TERM: begin
            if (hit) r.rterm = term_mem[ring_slot(off)];
            else if (idx == snap_num) r.rterm = snap_term;
         end
         CMD_MATCH: begin
            if (idx == 32'd0) r.matched = 1'b1;
            else if (idx == snap_num) r.matched = (snap_term == trm);
            else if (hit) r.matched = (term_mem[ring_slot(off)] == trm);
         end
         CMD_READ: begin
            if (hit) begin
               s = ring_slot(off);
               r.rterm = term_mem[s];
               r.rpay  = pay_mem[s];
            end else begin
               r.status = ST_READ_OOR;
            end
         end
         CMD_INSTALL: begin
            snap_num  = idx;
            snap_term = trm;
            log_base  = idx;
            log_count = '0;
            log_head  = '0;
         end
         default: ;
      endcase
      r.last_index  = log_base + 32'(log_count) - 32'd1;
      r.last_term   = (log_count == 0) ? snap_term
                                       : term_mem[ring_slot(32'(log_count) - 32'd1)];
      r.first_index = log_base;
      r.snap_index  = snap_num;
   endtask

   task automatic check_field(input string name, input logic [63:0] exp_v,
                              input logic [63:0] act_v);
      if (exp_v !== act_v) begin
         mismatches++;
         if (mismatches <= 10)
            $display("%0t %s: expected %h, got %h", $realtime, name, exp_v, act_v);
      end
   endtask

   always @(posedge clock) begin
      if (reset) begin
         log_head  = '0;
         log_count = '0;
         log_base  = 32'd1;
         snap_num  = 32'd1;
         snap_term = 32'd0;
         expected_q.delete();
      end else begin
         if (rsp_tvalid && rsp_tready) begin
            seen.status      = rsp_tdata[1:0];
            seen.rterm       = rsp_tdata[33:2];
            seen.rpay        = rsp_tdata[97:34];
            seen.matched     = rsp_tdata[98];
            seen.last_index  = rsp_tdata[130:99];
            seen.last_term   = rsp_tdata[162:131];
            seen.first_index = rsp_tdata[194:163];
            seen.snap_index  = rsp_tdata[226:195];
            if (expected_q.size() == 0) begin
               mismatches++;
               if (mismatches <= 10)
                  $display("%0t unexpected result transfer %h", $realtime, rsp_tdata);
            end else begin
               want = expected_q.pop_front();
               check_field("status",         64'(want.status),      64'(seen.status));
               check_field("result_term",    64'(want.rterm),       64'(seen.rterm));
               check_field("result_payload", want.rpay,             seen.rpay);
               check_field("matched",        64'(want.matched),     64'(seen.matched));
               check_field("last_index",     64'(want.last_index),  64'(seen.last_index));
               check_field("last_term",      64'(want.last_term),   64'(seen.last_term));
               check_field("first_index",    64'(want.first_index), 64'(seen.first_index));
               check_field("snap_index",     64'(want.snap_index),  64'(seen.snap_index));
            end
         end
         if (req_tvalid && req_tready) begin
            apply_command(req_tdata[2:0], req_tdata[34:3], req_tdata[66:35],
                          req_tdata[130:67], want);
            expected_q.push_back(want);
         end
      end
      fails      <= mismatches;
      pending    <= expected_q.size();
      hint_first <= log_base;
      hint_count <= log_count;
      hint_snap  <= snap_num;
   end

endmodule

>>> test/tb.sv
// Testbench top for the consensus log store: clock, reset, command stimulus and verdict.
module tb;
   import cls_pkg::*;

   localparam logic [2:0] CMD_UNUSED = 3'd7;
   localparam int         STALL_LIMIT = 2000;
   localparam int         LONG_HOLD   = 300;

   logic             clock = 1'b0;
   logic             reset;
   logic             req_tvalid;
   logic             req_tready;
   logic [REQ_W-1:0] req_tdata;
   logic             rsp_tvalid;
   logic             rsp_tready;
   logic [RSP_W-1:0] rsp_tdata;

   int               fails;
   int               pending;
   logic [31:0]      hint_first;
   logic [CNT_W-1:0] hint_count;
   logic [31:0]      hint_snap;

   logic quiet;
   logic hold_request;
   logic hold_taken;
   int   fill_n;
   int   stall;
   int   rsp_wait;

   consensus_log_store u_top (
      .clock      (clock),
      .reset      (reset),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .req_tdata  (req_tdata),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .rsp_tdata  (rsp_tdata)
   );

   cls_checker u_checker (
      .clock      (clock),
      .reset      (reset),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .req_tdata  (req_tdata),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .rsp_tdata  (rsp_tdata),
      .fails      (fails),
      .pending    (pending),
      .hint_first (hint_first),
      .hint_count (hint_count),
      .hint_snap  (hint_snap)
   );

   always begin
      #5 clock = 1'b1;
      #5 clock = 1'b0;
   end

   function automatic int draw_gap();
      return quiet ? 0 : $urandom_range(0, 16);
   endfunction

   function automatic logic [31:0] pick_index();
      case ($urandom_range(0, 11))
         0:       return $urandom;
         1:       return 32'd0;
         2:       return hint_snap;
         3:       return hint_first - 32'd1;
         4:       return hint_snap + 32'd1;
         default: return hint_first + 32'($urandom_range(0, 32'(hint_count) + 1));
      endcase
   endfunction

   function automatic logic [31:0] pick_term();
      return ($urandom_range(0, 7) == 0) ? $urandom : 32'($urandom_range(0, 3));
   endfunction

   task automatic send(input logic [2:0] c, input logic [31:0] idx,
                       input logic [31:0] trm, input logic [63:0] pay);
      int n;
      n = draw_gap();
      if (n > 0) begin
         req_tvalid <= 1'b0;
         repeat (n) @(posedge clock);
      end
      req_tvalid <= 1'b1;
      req_tdata  <= {5'b0, pay, trm, idx, c};
      @(posedge clock);
      while (!req_tready) @(posedge clock);
   endtask

   task automatic run_mixed(input int n, input int append_pct);
      logic [2:0] c;
      int         r;
      repeat (n) begin
         if ($urandom_range(0, 99) < append_pct) begin
            c = CMD_APPEND;
         end else begin
            r = $urandom_range(0, 99);
            if (r < 10)      c = CMD_DROP;
            else if (r < 20) c = CMD_COMPACT;
            else if (r < 38) c = CMD_TERM;
            else if (r < 60) c = CMD_MATCH;
            else if (r < 85) c = CMD_READ;
            else if (r < 95) c = CMD_INSTALL;
            else             c = CMD_UNUSED;
         end
         send(c, (c == CMD_INSTALL && $urandom_range(0, 1)) ? $urandom : pick_index(),
              pick_term(), {$urandom, $urandom});
      end
   endtask

   // response side: random ready gaps per result, one long hold on request
   initial begin
      rsp_tready = 1'b0;
      hold_taken = 1'b0;
      @(posedge clock);
      forever begin
         rsp_wait = draw_gap();
         if (hold_request && !hold_taken) begin
            rsp_wait   = LONG_HOLD;
            hold_taken = 1'b1;
         end
         if (rsp_wait > 0) begin
            rsp_tready <= 1'b0;
            repeat (rsp_wait) @(posedge clock);
         end
         rsp_tready <= 1'b1;
         @(posedge clock);
         while (!rsp_tvalid) @(posedge clock);
      end
   end

   initial begin
      stall = 0;
      while (stall < STALL_LIMIT) begin
         @(posedge clock);
         if ((req_tvalid && req_tready) || (rsp_tvalid && rsp_tready)) stall = 0;
         else stall++;
      end
      $display("consensus_log_store: mismatch");
      $finish;
   end

   initial begin
      reset        = 1'b1;
      req_tvalid   = 1'b0;
      req_tdata    = '0;
      quiet        = 1'b0;
      hold_request = 1'b0;
      repeat (5) @(posedge clock);
      reset <= 1'b0;

      send(CMD_READ,    32'd1, 32'd0, 64'd0);
      send(CMD_TERM,    32'd1, 32'd0, 64'd0);
      send(CMD_MATCH,   32'd0, 32'd5, 64'd0);
      send(CMD_MATCH,   32'd1, 32'd5, 64'd0);
      send(CMD_APPEND,  32'd0, 32'd0, 64'd0);
      send(CMD_APPEND,  32'hFFFF_FFFF, 32'hFFFF_FFFF, 64'hFFFF_FFFF_FFFF_FFFF);
      send(CMD_APPEND,  32'd0, 32'd3, {$urandom, $urandom});
      send(CMD_READ,    32'd2, 32'd0, 64'd0);
      send(CMD_READ,    32'd4, 32'd0, 64'd0);
      send(CMD_READ,    32'hFFFF_FFFF, 32'd0, 64'd0);
      send(CMD_TERM,    32'd0, 32'd0, 64'd0);
      send(CMD_MATCH,   32'd2, 32'hFFFF_FFFF, 64'd0);
      send(CMD_DROP,    32'd4, 32'd0, 64'd0);
      send(CMD_COMPACT, 32'd1, 32'd0, 64'd0);
      send(CMD_COMPACT, 32'd5, 32'd0, 64'd0);
      send(CMD_COMPACT, 32'd3, 32'd0, 64'd0);
      send(CMD_TERM,    32'd2, 32'd0, 64'd0);
      send(CMD_DROP,    32'd3, 32'd0, 64'd0);
      send(CMD_UNUSED,  32'hFFFF_FFFF, 32'hFFFF_FFFF, 64'hFFFF_FFFF_FFFF_FFFF);
      send(CMD_INSTALL, 32'hFFFF_FFFF, 32'hFFFF_FFFF, 64'd0);
      send(CMD_APPEND,  32'd0, 32'd7, {$urandom, $urandom});
      send(CMD_APPEND,  32'd0, 32'd8, {$urandom, $urandom});
      send(CMD_TERM,    32'd0, 32'd0, 64'd0);
      send(CMD_MATCH,   32'hFFFF_FFFF, 32'hFFFF_FFFF, 64'd0);
      send(CMD_INSTALL, 32'd0, 32'd0, 64'd0);
      send(CMD_MATCH,   32'd0, 32'd9, 64'd0);

      run_mixed(250, 35);

      // fill the ring to capacity; back-pressure the result side meanwhile
      quiet        = 1'b1;
      hold_request = 1'b1;
      fill_n       = LOG_DEPTH - int'(hint_count) + 8;
      repeat (fill_n / 2) send(CMD_APPEND, $urandom, pick_term(), {$urandom, $urandom});
      quiet = 1'b0;
      repeat (fill_n - fill_n / 2) send(CMD_APPEND, $urandom, pick_term(),
                                        {$urandom, $urandom});
      send(CMD_READ,    hint_first + 32'(hint_count) - 32'd1, 32'd0, 64'd0);
      send(CMD_COMPACT, hint_first + 32'd600, 32'd0, 64'd0);

      // appends past the end of the ring, then mixed traffic across the wrap
      repeat (100) send(CMD_APPEND, $urandom, pick_term(), {$urandom, $urandom});
      run_mixed(150, 30);

      send(CMD_INSTALL, 32'hFFFF_FFF0 + 32'($urandom_range(0, 15)), $urandom, 64'd0);
      run_mixed(60, 60);
      quiet = 1'b1;
      send(CMD_INSTALL, $urandom, $urandom, {$urandom, $urandom});
      run_mixed(40, 40);
      quiet = 1'b0;
      req_tvalid <= 1'b0;

      @(posedge clock);
      while (pending != 0) @(posedge clock);
      repeat (8) @(posedge clock);
      if (fails == 0 && pending == 0) begin
         $display("consensus_log_store: match");
      end else begin
         $display("consensus_log_store: mismatch");
      end
      $finish;
   end

endmodule

>>> sim.f
design/cls_pkg.sv
design/cls_ctrl.sv
design/cls_datapath.sv
design/consensus_log_store.sv
test/cls_checker.sv
test/tb.sv
